### src/assert_macros.svh
// Assertion macros used by the RTL of the field serializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion that is switched off while reset is high.
`define FSBV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Clocked assertion that also holds during reset.
`define FSBV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FSBV_ASSERT(lbl, clk, rst, prop)
`define FSBV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### src/fsbv_pkg.sv
// Package with the codes and types of the field serializer.
`default_nettype none
package fsbv_pkg;

  // Field kinds carried on func.
  localparam logic [2:0] FN_BYTE   = 3'd0;
  localparam logic [2:0] FN_BIT    = 3'd1;
  localparam logic [2:0] FN_U16    = 3'd2;
  localparam logic [2:0] FN_U32    = 3'd3;
  localparam logic [2:0] FN_U64    = 3'd4;
  localparam logic [2:0] FN_VARINT = 3'd5;
  localparam logic [2:0] FN_FLUSH  = 3'd6;

  // Sequencer states, also used to select the emit unit's operation.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ALIGN  = 2'd1;
  localparam logic [1:0] ST_BE     = 2'd2;
  localparam logic [1:0] ST_VARINT = 2'd3;

  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] MORE_FLAG  = 8'h80;
  localparam int unsigned GROUP_BITS = 7;

  // One byte produced by the emit unit.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } emit_t;

endpackage
`default_nettype wire

### src/fsbv_emit_unit.sv
// Shared byte emit unit: forms the next output byte and the shifted work word.
`default_nettype none
module fsbv_emit_unit (
  input  logic [1:0]          mode,
  input  logic [63:0]         shreg,
  input  logic [3:0]          cnt,
  input  logic [7:0]          pending_bits,
  input  logic                align_last,
  output fsbv_pkg::emit_t     res,
  output logic [63:0]         shreg_next
);

  logic [24:0] rest;

  assign rest = shreg[31:fsbv_pkg::GROUP_BITS];

  always_comb begin
    res        = '0;
    shreg_next = shreg;
    case (mode)
      fsbv_pkg::ST_ALIGN: begin
        res.data = pending_bits;
        res.last = align_last;
      end
      fsbv_pkg::ST_BE: begin
        res.data   = shreg[63:56];
        res.last   = (cnt == 4'd1);
        shreg_next = {shreg[55:0], 8'h00};
      end
      fsbv_pkg::ST_VARINT: begin
        res.data = (shreg[7:0] & fsbv_pkg::GROUP_MASK)
                 | ((rest != 25'd0) ? fsbv_pkg::MORE_FLAG : 8'h00);
        res.last   = (rest == 25'd0);
        shreg_next = {39'd0, rest};
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/field_serializer_bitpack_varint.sv
// Top level of the big-endian field serializer with bit packing and varints.
//
// The input channel (in_valid, in_ready, func, value) carries one field per
// request. The output channel (out_valid, out_ready, out_byte, last) carries
// one serialized byte per request, in stream order; last marks the final byte
// that a field produced.
// A request is taken only while the sequencer is idle. After that the shared
// emit unit produces one byte per cycle while the output register is free or
// drains, and no new field is taken until the field's final byte has gone
// into the output register. A single bit that does not complete a byte, a
// flush with nothing pending and the unused func code produce nothing.
// Bytes leave through one output register; a stalled receiver holds that
// register and the sequencer waits. A new field can be taken while the final
// byte of the previous one still waits.
// Reset clears the pending bit byte, the sequencer and the output valid flag.
`default_nettype none
module field_serializer_bitpack_varint (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last
);

  // Sequencer and work registers.
  logic [1:0]  state, state_next;
  logic [1:0]  after_align, after_align_next;
  logic [63:0] shreg, shreg_next;
  logic [3:0]  cnt, cnt_next;
  // Bit packing state: bits collected MSB-first and how many there are.
  logic [7:0]  pending_bits, pending_bits_next;
  logic [2:0]  bit_fill, bit_fill_next;

  fsbv_pkg::emit_t emit_res;
  logic [63:0]     unit_shreg;
  logic            emit_go;
  logic            in_fire;

  assign in_ready = (state == fsbv_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  // A byte moves into the output register when the register is free or drains.
  assign emit_go  = (state != fsbv_pkg::ST_IDLE) && (!out_valid || out_ready);

  fsbv_emit_unit u_emit (
    .mode         (state),
    .shreg        (shreg),
    .cnt          (cnt),
    .pending_bits (pending_bits),
    .align_last   (after_align == fsbv_pkg::ST_IDLE),
    .res          (emit_res),
    .shreg_next   (unit_shreg)
  );

  always_comb begin
    state_next        = state;
    after_align_next  = after_align;
    shreg_next        = shreg;
    cnt_next          = cnt;
    pending_bits_next = pending_bits;
    bit_fill_next     = bit_fill;

    if (in_fire) begin
      case (func)
        fsbv_pkg::FN_BIT: begin
          if (value[0]) begin
            pending_bits_next = pending_bits | (fsbv_pkg::MORE_FLAG >> bit_fill);
          end
          if (bit_fill == 3'd7) begin
            // The eighth bit sends the full byte out as this field's only byte.
            state_next       = fsbv_pkg::ST_ALIGN;
            after_align_next = fsbv_pkg::ST_IDLE;
          end else begin
            bit_fill_next = bit_fill + 3'd1;
          end
        end
        fsbv_pkg::FN_BYTE, fsbv_pkg::FN_U16, fsbv_pkg::FN_U32,
        fsbv_pkg::FN_U64, fsbv_pkg::FN_VARINT: begin
          case (func)
            fsbv_pkg::FN_BYTE: begin
              shreg_next = {value[7:0], 56'd0};
              cnt_next   = 4'd1;
            end
            fsbv_pkg::FN_U16: begin
              shreg_next = {value[15:0], 48'd0};
              cnt_next   = 4'd2;
            end
            fsbv_pkg::FN_U32: begin
              shreg_next = {value[31:0], 32'd0};
              cnt_next   = 4'd4;
            end
            fsbv_pkg::FN_U64: begin
              shreg_next = value;
              cnt_next   = 4'd8;
            end
            default: begin
              shreg_next = {32'd0, value[31:0]};
              cnt_next   = 4'd0;
            end
          endcase
          after_align_next = (func == fsbv_pkg::FN_VARINT) ? fsbv_pkg::ST_VARINT
                                                           : fsbv_pkg::ST_BE;
          // A partly filled bit byte goes out first.
          state_next = (bit_fill != 3'd0) ? fsbv_pkg::ST_ALIGN : after_align_next;
        end
        fsbv_pkg::FN_FLUSH: begin
          if (bit_fill != 3'd0) begin
            state_next       = fsbv_pkg::ST_ALIGN;
            after_align_next = fsbv_pkg::ST_IDLE;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end else if (emit_go) begin
      case (state)
        fsbv_pkg::ST_ALIGN: begin
          pending_bits_next = 8'h00;
          bit_fill_next     = 3'd0;
          state_next        = after_align;
        end
        fsbv_pkg::ST_BE: begin
          shreg_next = unit_shreg;
          cnt_next   = cnt - 4'd1;
          state_next = emit_res.last ? fsbv_pkg::ST_IDLE : fsbv_pkg::ST_BE;
        end
        fsbv_pkg::ST_VARINT: begin
          shreg_next = unit_shreg;
          state_next = emit_res.last ? fsbv_pkg::ST_IDLE : fsbv_pkg::ST_VARINT;
        end
        default: begin
          state_next = fsbv_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fsbv_pkg::ST_IDLE;
      after_align  <= fsbv_pkg::ST_IDLE;
      pending_bits <= 8'h00;
      bit_fill     <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      after_align  <= after_align_next;
      pending_bits <= pending_bits_next;
      bit_fill     <= bit_fill_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work word and output payload need no reset.
  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    cnt   <= cnt_next;
    if (emit_go) begin
      out_byte <= emit_res.data;
      last     <= emit_res.last;
    end
  end

`include "assert_macros.svh"

  // While idle, bits below the filled positions of the pending byte are zero.
  `FSBV_ASSERT(a_pending_clean, clk, rst, (state == fsbv_pkg::ST_IDLE) |-> ((pending_bits & (8'hFF >> bit_fill)) == 8'h00))
  // The big-endian byte count never runs out while bytes remain to be sent.
  `FSBV_ASSERT(a_be_count, clk, rst, (state == fsbv_pkg::ST_BE) |-> (cnt != 4'd0))
  // The byte that ends a field returns the sequencer to idle.
  `FSBV_ASSERT(a_last_idle, clk, rst, (emit_go && emit_res.last) |=> (state == fsbv_pkg::ST_IDLE))

endmodule
`default_nettype wire

### sim/tb_field_serializer_bitpack_varint.sv
// Self-checking testbench for the big-endian field serializer with bit packing and varints.
`default_nettype none
module tb_field_serializer_bitpack_varint;
  timeunit 1ns;
  timeprecision 1ps;

  import fsbv_pkg::*;

  // The one func code that the block does not use; it must be swallowed silently.
  localparam logic [2:0] FN_UNUSED = 3'd7;

  // Number of random requests after the directed part.
  localparam int RANDOM_REQS = 250;
  // Idle cycles that the watchdog tolerates before it calls the run hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to settle after the last expected byte.
  localparam int SETTLE_CYCLES = 16;
  // Window of accepted requests in which neither side ever idles.
  localparam int CALM_FROM = 110;
  localparam int CALM_TO = 170;

  // One field request waiting to be driven.
  typedef struct {
    logic [2:0]  kind;
    logic [63:0] val;
  } field_req_t;

  // One serialized byte that the block is expected to produce.
  typedef struct {
    logic [7:0] data;
    logic       fin;
  } stream_octet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = FN_BYTE;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  field_req_t    pending_reqs[$];
  stream_octet_t expected_stream[$];
  field_req_t    next_req;
  stream_octet_t head_octet;

  // Mirror of the block's bit packer: bits collected so far and how many there are.
  logic [7:0] packed_bits;
  logic [2:0] packed_count;

  int mismatches = 0;
  int reqs_taken = 0;
  int bytes_checked = 0;
  int idle_cycles = 0;
  int kind_seen[8];
  logic calm;

  field_serializer_bitpack_varint uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last)
  );

  always #5 clk = ~clk;

  assign calm = (reqs_taken >= CALM_FROM) && (reqs_taken < CALM_TO);

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Works out the bytes that one accepted field produces and queues them in stream
  // order. The last byte of the field carries the end flag.
  task automatic serialize_field(input logic [2:0] kind, input logic [63:0] val);
    logic [7:0]  octets[9];
    logic [31:0] raw;
    logic [7:0]  grp;
    int          n;
    int          nbytes;
    n = 0;
    nbytes = 0;
    // Every byte-type field and a flush first push out a partly filled bit byte.
    if (kind inside {FN_BYTE, FN_U16, FN_U32, FN_U64, FN_VARINT, FN_FLUSH}) begin
      if (packed_count != 0) begin
        octets[n] = packed_bits;
        n++;
        packed_bits = '0;
        packed_count = '0;
      end
    end
    case (kind)
      FN_BYTE: begin
        octets[n] = val[7:0];
        n++;
      end
      FN_BIT: begin
        // Bits fill the pending byte from the MSB down; the eighth one sends it.
        if (val[0])
          packed_bits = packed_bits | (MORE_FLAG >> packed_count);
        if (packed_count == 3'd7) begin
          octets[n] = packed_bits;
          n++;
          packed_bits = '0;
          packed_count = '0;
        end else begin
          packed_count = packed_count + 3'd1;
        end
      end
      FN_U16, FN_U32, FN_U64: begin
        nbytes = (kind == FN_U16) ? 2 : (kind == FN_U32) ? 4 : 8;
        for (int i = nbytes - 1; i >= 0; i--) begin
          octets[n] = val[8*i +: 8];
          n++;
        end
      end
      FN_VARINT: begin
        // Seven-bit groups, low group first, with the top bit set while more follow.
        // A zero value still gives one byte.
        raw = val[31:0];
        do begin
          grp = raw[7:0] & GROUP_MASK;
          raw = raw >> GROUP_BITS;
          if (raw != 0)
            grp = grp | MORE_FLAG;
          octets[n] = grp;
          n++;
        end while (raw != 0);
      end
      default: begin
        // A flush has done its work above; the unused code changes nothing.
      end
    endcase
    for (int i = 0; i < n; i++)
      expected_stream.push_back('{data: octets[i], fin: (i == n - 1)});
  endtask

  task automatic add_req(input logic [2:0] kind, input logic [63:0] val);
    pending_reqs.push_back('{kind: kind, val: val});
  endtask

  // Request driver. It predicts the bytes of each request at the edge where the
  // request is taken, then either loads the next request or drives in_valid low.
  // in_valid is not reassigned while a request waits, so a held request never drops.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      packed_bits = '0;
      packed_count = '0;
    end else begin
      if (in_valid && in_ready) begin
        serialize_field(func, value);
        kind_seen[func]++;
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          func <= next_req.kind;
          value <= next_req.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Byte receiver: stalls at random except inside the calm window.
  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  // Output monitor. Each byte taken is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_stream.size() == 0) begin
        report_mismatch($sformatf("byte %02h (last %0b) arrived with nothing expected",
                                  out_byte, last));
      end else begin
        head_octet = expected_stream.pop_front();
        if (out_byte !== head_octet.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte,
                                    head_octet.data));
        if (last !== head_octet.fin)
          report_mismatch($sformatf("last %0b on byte %02h, expected %0b", last,
                                    out_byte, head_octet.fin));
      end
    end
  end

  // Watchdog: a run that stops moving on both channels is declared hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no traffic for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int choice;
    int run_len;
    int queued;
    logic [2:0] kind;
    logic [63:0] val;

    // Directed part. Unused upper value bits are set on purpose in many requests.
    add_req(FN_FLUSH, 64'h0);                       // flush with nothing pending
    add_req(FN_BYTE, 64'h0);
    add_req(FN_BYTE, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FN_U16, 64'hDEAD_BEEF_0000_0000);
    add_req(FN_U16, 64'h1234_5678_9ABC_FFFF);
    add_req(FN_U32, 64'hFFFF_FFFF_0000_0000);
    add_req(FN_U32, 64'h0000_0000_FFFF_FFFF);
    add_req(FN_U64, 64'h0123_4567_89AB_CDEF);
    add_req(FN_U64, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FN_VARINT, 64'hFFFF_FFFF_0000_0000);    // varint of zero: one 00 byte
    add_req(FN_VARINT, 64'h0000_0000_0000_007F);
    add_req(FN_VARINT, 64'h0000_0000_0000_0080);
    add_req(FN_VARINT, 64'hFFFF_FFFF_FFFF_FFFF);    // five groups
    // Eight bits complete a byte on their own: 1010_0111.
    add_req(FN_BIT, 64'h1);
    add_req(FN_BIT, 64'hFFFF_FFFF_FFFF_FFFE);
    add_req(FN_BIT, 64'h1);
    add_req(FN_BIT, 64'h0);
    add_req(FN_BIT, 64'h0);
    add_req(FN_BIT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FN_BIT, 64'h1);
    add_req(FN_BIT, 64'h3);
    // Partial byte, then the unused code, then a u64 that flushes it: nine bytes.
    add_req(FN_BIT, 64'h1);
    add_req(FN_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FN_U64, 64'h8000_0000_0000_0001);
    add_req(FN_BIT, 64'h1);
    add_req(FN_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF);     // flush of one pending bit

    // Random part. Bits come in runs so that pending bytes of every fill level
    // meet every other kind of field.
    queued = 0;
    while (queued < RANDOM_REQS) begin
      choice = $urandom_range(0, 99);
      if (choice < 30) begin
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++)
          add_req(FN_BIT, {$urandom, $urandom});
        queued += run_len;
      end else begin
        if (choice < 42)      kind = FN_BYTE;
        else if (choice < 52) kind = FN_U16;
        else if (choice < 62) kind = FN_U32;
        else if (choice < 72) kind = FN_U64;
        else if (choice < 87) kind = FN_VARINT;
        else if (choice < 95) kind = FN_FLUSH;
        else                  kind = FN_UNUSED;
        choice = $urandom_range(0, 99);
        if (choice < 5)
          val = '0;
        else if (choice < 10)
          val = '1;
        else if (kind == FN_VARINT)
          // Shift the low word so that every varint length shows up.
          val = {$urandom, $urandom >> $urandom_range(0, 31)};
        else
          val = {$urandom, $urandom};
        add_req(kind, val);
        queued++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything driven, every predicted byte seen, then a quiet tail.
    while (pending_reqs.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_stream.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_stream.size() != 0)
      report_mismatch($sformatf("%0d predicted bytes never arrived",
                                expected_stream.size()));

    $display("Run covered %0d requests (byte %0d, bit %0d, u16 %0d, u32 %0d, u64 %0d,",
             reqs_taken, kind_seen[FN_BYTE], kind_seen[FN_BIT], kind_seen[FN_U16],
             kind_seen[FN_U32], kind_seen[FN_U64]);
    $display("  varint %0d, flush %0d, unused %0d) and checked %0d bytes, %0d mismatches.",
             kind_seen[FN_VARINT], kind_seen[FN_FLUSH], kind_seen[FN_UNUSED],
             bytes_checked, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
